// ----- sv/foc_decoupling_voltage_step_macros.svh -----
// Assertion helpers for the control-path module.
`ifndef FOC_DECOUPLING_VOLTAGE_STEP_MACROS_SVH
`define FOC_DECOUPLING_VOLTAGE_STEP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FDVS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FDVS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- sv/fdvs_pkg.sv -----
package fdvs_pkg;

  localparam int unsigned GainW  = 15;
  localparam int unsigned DataW  = 16;
  localparam int unsigned AngleW = 15;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned InW    = 48;
  localparam int unsigned OutW   = 80;

  // register indexes
  localparam logic [IdxW-1:0] RegRs    = 3'd0;
  localparam logic [IdxW-1:0] RegSigma = 3'd1;
  localparam logic [IdxW-1:0] RegLs    = 3'd2;
  localparam logic [IdxW-1:0] RegSlip  = 3'd3;
  localparam logic [IdxW-1:0] RegAngle = 3'd4;

  // reset values
  localparam logic [GainW-1:0] RstRs    = 15'd162;
  localparam logic [GainW-1:0] RstSigma = 15'd253;
  localparam logic [GainW-1:0] RstLs    = 15'd3009;
  localparam logic [GainW-1:0] RstSlip  = 15'd193;
  localparam logic [GainW-1:0] RstAngle = 15'd328;

  localparam logic [DataW-1:0] SatPos = 16'h7FFF;
  localparam logic [DataW-1:0] SatNeg = 16'h8000;

  // divider runs one quotient bit per cycle over the 31-bit numerator magnitude
  localparam int unsigned NumW = 31;
  localparam logic [4:0]  DivLast = 5'(NumW - 1);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_NUM  = 12'b0000_0000_0010,
    ST_DINI = 12'b0000_0000_0100,
    ST_DIV  = 12'b0000_0000_1000,
    ST_SLIP = 12'b0000_0001_0000,
    ST_ANG  = 12'b0000_0010_0000,
    ST_RSD  = 12'b0000_0100_0000,
    ST_RSQ  = 12'b0000_1000_0000,
    ST_WQ   = 12'b0001_0000_0000,
    ST_SGD  = 12'b0010_0000_0000,
    ST_WD   = 12'b0100_0000_0000,
    ST_LS   = 12'b1000_0000_0000
  } state_e;

endpackage

// ----- sv/foc_decoupling_voltage_step.sv -----
// Decoupling voltage step for indirect field-oriented control. Each input transfer carries
// the d/q current references and the measured speed; each produces exactly one output
// transfer with the decoupled d/q voltage commands, the updated 15-bit flux angle, the
// stator frequency and the saturated slip frequency. All multiplication runs on one shared
// 19x16 signed multiplier plus a one-bit-per-cycle restoring divider under a small
// sequencer. Output valid rises in the same cycle in which the input side is ready again;
// no new item is taken while one is still in the sequencer, and the 31-bit slip division
// takes most of each item's time. A finished result waits in the output register, and the
// next item is taken meanwhile; the sequencer only stalls at its last step if the previous
// result has still not been taken. The user must write gains through the cfg port only
// while the block is idle; the block does not enforce it. Out-of-range indexes are ignored.
module foc_decoupling_voltage_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cfg write port
  input  logic                          cfg_we_i,
  input  logic [fdvs_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [fdvs_pkg::GainW-1:0]    cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] d_current_ref, [31:16] q_current_ref, [47:32] rotor_speed
  input  logic [fdvs_pkg::InW-1:0]      s_axis_tdata,
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] d_voltage_ref, [31:16] q_voltage_ref, [46:32] flux_angle,
  // [62:47] stator_frequency, [78:63] slip_frequency, [79] zero
  output logic [fdvs_pkg::OutW-1:0]     m_axis_tdata
);

  `include "foc_decoupling_voltage_step_macros.svh"

  // gain registers
  logic [fdvs_pkg::GainW-1:0] rs_q, sg_q, ls_q, slg_q, ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q  <= fdvs_pkg::RstRs;
      sg_q  <= fdvs_pkg::RstSigma;
      ls_q  <= fdvs_pkg::RstLs;
      slg_q <= fdvs_pkg::RstSlip;
      ang_q <= fdvs_pkg::RstAngle;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fdvs_pkg::RegRs:    rs_q  <= cfg_wdata_i;
        fdvs_pkg::RegSigma: sg_q  <= cfg_wdata_i;
        fdvs_pkg::RegLs:    ls_q  <= cfg_wdata_i;
        fdvs_pkg::RegSlip:  slg_q <= cfg_wdata_i;
        fdvs_pkg::RegAngle: ang_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  fdvs_pkg::state_e state_q, state_d;

  logic signed [15:0] isd_q, isq_q, spd_q;
  logic signed [34:0] prod_q;
  logic        [15:0] rem_q, dvs_q;
  logic        [30:0] quo_q;
  logic        [4:0]  cnt_q;
  logic               num_neg_q;
  logic        [15:0] slip_q, w_q, p1d_q, p1q_q, vsd_q;
  logic        [14:0] acc_q;
  logic [fdvs_pkg::OutW-1:0] out_q;
  logic               out_valid_q;

  logic in_fire, out_fire, out_free;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = out_valid_q && m_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == fdvs_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // shared multiplier: operand select by step
  logic signed [18:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [34:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      fdvs_pkg::ST_NUM: begin
        mul_a = 19'(isq_q);
        mul_b = $signed({1'b0, slg_q});
      end
      fdvs_pkg::ST_ANG: begin
        mul_a = 19'($signed(w_q));
        mul_b = $signed({1'b0, ang_q});
      end
      fdvs_pkg::ST_RSD: begin
        mul_a = 19'(isd_q);
        mul_b = $signed({1'b0, rs_q});
      end
      fdvs_pkg::ST_RSQ: begin
        mul_a = 19'(isq_q);
        mul_b = $signed({1'b0, rs_q});
      end
      fdvs_pkg::ST_WQ: begin
        mul_a = 19'($signed(w_q));
        mul_b = isq_q;
      end
      fdvs_pkg::ST_SGD: begin
        mul_a = prod_q[31:13];
        mul_b = $signed({1'b0, sg_q});
      end
      fdvs_pkg::ST_WD: begin
        mul_a = 19'($signed(w_q));
        mul_b = isd_q;
      end
      fdvs_pkg::ST_LS: begin
        mul_a = prod_q[31:13];
        mul_b = $signed({1'b0, ls_q});
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // numerator with its low bit cleared, and its magnitude
  logic [30:0] num;
  logic [30:0] num_mag;
  assign num     = {prod_q[30:1], 1'b0};
  assign num_mag = num[30] ? (~num + 31'd1) : num;

  // one restoring divide step
  logic [16:0] rem_sh;
  logic [17:0] diff;
  logic        ge;
  assign rem_sh = {rem_q, quo_q[30]};
  assign diff   = {1'b0, rem_sh} - {2'b0, dvs_q};
  assign ge     = !diff[17];

  // slip saturation and stator frequency
  logic        quo_neg;
  logic [15:0] slip_sat, w_new;
  assign quo_neg = num_neg_q ^ isd_q[15];

  always_comb begin
    priority if (isd_q == '0) begin
      slip_sat = num_neg_q ? fdvs_pkg::SatNeg : fdvs_pkg::SatPos;
    end else if (quo_neg) begin
      slip_sat = (quo_q > 31'd32768) ? fdvs_pkg::SatNeg : (~quo_q[15:0] + 16'd1);
    end else begin
      slip_sat = (quo_q > 31'd32767) ? fdvs_pkg::SatPos : quo_q[15:0];
    end
  end

  assign w_new = {spd_q[13:0], 2'b00} + slip_sat;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fdvs_pkg::ST_IDLE: if (in_fire) state_d = fdvs_pkg::ST_NUM;
      fdvs_pkg::ST_NUM:  state_d = fdvs_pkg::ST_DINI;
      fdvs_pkg::ST_DINI: state_d = fdvs_pkg::ST_DIV;
      fdvs_pkg::ST_DIV:  if (cnt_q == '0) state_d = fdvs_pkg::ST_SLIP;
      fdvs_pkg::ST_SLIP: state_d = fdvs_pkg::ST_ANG;
      fdvs_pkg::ST_ANG:  state_d = fdvs_pkg::ST_RSD;
      fdvs_pkg::ST_RSD:  state_d = fdvs_pkg::ST_RSQ;
      fdvs_pkg::ST_RSQ:  state_d = fdvs_pkg::ST_WQ;
      fdvs_pkg::ST_WQ:   state_d = fdvs_pkg::ST_SGD;
      fdvs_pkg::ST_SGD:  state_d = fdvs_pkg::ST_WD;
      fdvs_pkg::ST_WD:   state_d = fdvs_pkg::ST_LS;
      fdvs_pkg::ST_LS:   if (out_free) state_d = fdvs_pkg::ST_IDLE;
      default:           state_d = fdvs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fdvs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == fdvs_pkg::ST_LS && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      // angle accumulates the floor-shifted step, wrapping at 15 bits
      if (state_q == fdvs_pkg::ST_RSD) begin
        acc_q <= acc_q + prod_q[27:13];
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      fdvs_pkg::ST_IDLE: begin
        if (in_fire) begin
          isd_q <= s_axis_tdata[15:0];
          isq_q <= s_axis_tdata[31:16];
          spd_q <= s_axis_tdata[47:32];
        end
      end
      fdvs_pkg::ST_DINI: begin
        num_neg_q <= num[30];
        quo_q     <= num_mag;
        rem_q     <= '0;
        dvs_q     <= isd_q[15] ? (~isd_q + 16'sd1) : isd_q;
        cnt_q     <= fdvs_pkg::DivLast;
      end
      fdvs_pkg::ST_DIV: begin
        rem_q <= ge ? diff[15:0] : rem_sh[15:0];
        quo_q <= {quo_q[29:0], ge};
        cnt_q <= cnt_q - 5'd1;
      end
      fdvs_pkg::ST_SLIP: begin
        slip_q <= slip_sat;
        w_q    <= w_new;
      end
      fdvs_pkg::ST_RSQ: p1d_q <= prod_q[27:12];
      fdvs_pkg::ST_WQ:  p1q_q <= prod_q[27:12];
      fdvs_pkg::ST_WD:  vsd_q <= p1d_q - prod_q[27:12];
      fdvs_pkg::ST_LS: begin
        if (out_free) begin
          out_q <= {1'b0, slip_q, w_q, acc_q, p1q_q + mul_p[27:12], vsd_q};
        end
      end
      default: ;
    endcase
    if (state_q == fdvs_pkg::ST_NUM || state_q == fdvs_pkg::ST_ANG ||
        state_q == fdvs_pkg::ST_RSD || state_q == fdvs_pkg::ST_RSQ ||
        state_q == fdvs_pkg::ST_WQ  || state_q == fdvs_pkg::ST_SGD ||
        state_q == fdvs_pkg::ST_WD) begin
      prod_q <= mul_p;
    end
  end

  // checks
  logic div_done, slip_pinned;
  assign div_done    = (state_q == fdvs_pkg::ST_DIV) && (cnt_q == '0);
  assign slip_pinned = (slip_q == fdvs_pkg::SatPos) || (slip_q == fdvs_pkg::SatNeg);

  `FDVS_ASSERT_NXT(a_accept_starts, in_fire, state_q == fdvs_pkg::ST_NUM)
  `FDVS_ASSERT_NXT(a_div_ends, div_done, state_q == fdvs_pkg::ST_SLIP)
  `FDVS_ASSERT_NXT(a_done_valid, (state_q == fdvs_pkg::ST_LS) && out_free, out_valid_q)
  `FDVS_ASSERT_NXT(a_zero_div_sat, (state_q == fdvs_pkg::ST_SLIP) && (isd_q == '0), slip_pinned)

endmodule

// ----- tb/foc_decoupling_voltage_step_tb.sv -----
`timescale 1ns / 100ps

module foc_decoupling_voltage_step_tb;

  // fractional widths of the Q formats used by the voltage and angle paths
  localparam int unsigned CurFrac  = 12;
  localparam int unsigned FreqFrac = 13;

  // one output transfer, laid out exactly as m_axis_tdata (MSB first)
  typedef struct packed {
    logic                              pad;
    logic signed [fdvs_pkg::DataW-1:0] slip_freq;
    logic signed [fdvs_pkg::DataW-1:0] stator_freq;
    logic [fdvs_pkg::AngleW-1:0]       angle;
    logic signed [fdvs_pkg::DataW-1:0] q_volt;
    logic signed [fdvs_pkg::DataW-1:0] d_volt;
  } result_t;

  // one stimulus row: input fields, plus an optional hand-written expectation
  typedef struct packed {
    logic signed [fdvs_pkg::DataW-1:0] id;
    logic signed [fdvs_pkg::DataW-1:0] iq;
    logic signed [fdvs_pkg::DataW-1:0] speed;
    logic                              chk;
    result_t                           want;
  } row_t;

  typedef enum logic [2:0] {
    GainsMax,
    GainsZero,
    GainsMixed,
    GainsRandom,
    GainsNominal
  } gain_mode_e;

  // All-zero input right after reset: zero divisor with a non-negative numerator,
  // so slip and stator frequency pin at +full scale; angle steps by 328*32767>>13.
  localparam result_t ExpZeroIn = '{pad: 1'b0, slip_freq: fdvs_pkg::SatPos,
                                    stator_freq: fdvs_pkg::SatPos, angle: 15'd1311,
                                    q_volt: 16'sd0, d_volt: 16'sd0};
  // Zero divisor, negative numerator: slip and frequency pin at -full scale, the
  // angle steps back by 1312 and wraps below zero; only Rs*isq>>12 = -1 survives.
  localparam result_t ExpZeroDivNeg = '{pad: 1'b0, slip_freq: fdvs_pkg::SatNeg,
                                        stator_freq: fdvs_pkg::SatNeg, angle: 15'h7FFF,
                                        q_volt: -16'sd1, d_volt: 16'sd0};

  // directed rows, run with reset gains: id, iq, speed, typed check, expectation
  localparam int unsigned NumDir = 22;
  localparam row_t DirRows [NumDir] = '{
    '{16'sd0,      16'sd0,      16'sd0,      1'b1, ExpZeroIn},     // reset state
    '{16'sd0,      -16'sd1,     16'sd0,      1'b1, ExpZeroDivNeg}, // zero id, neg num
    '{16'sd1,      16'sd32767,  16'sd0,      1'b0, '0},  // quotient saturates high
    '{-16'sd1,     16'sd32767,  16'sd0,      1'b0, '0},  // quotient saturates low
    '{-16'sd1,     16'sh8000,   16'sd0,      1'b0, '0},
    '{16'sh8000,   16'sh8000,   16'sh8000,   1'b0, '0},  // all at min
    '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, '0},  // all at max
    '{16'sh8000,   16'sd32767,  16'sd32767,  1'b0, '0},
    '{16'sd32767,  16'sh8000,   16'sh8000,   1'b0, '0},
    '{16'sd0,      16'sd1,      16'sd100,    1'b0, '0},  // zero id, pos num
    '{16'sd0,      16'sh8000,   16'sh8000,   1'b0, '0},
    '{16'sd7,      -16'sd5,     16'sd3,      1'b0, '0},  // negative quotient
    '{-16'sd7,     16'sd5,      -16'sd3,     1'b0, '0},
    '{16'sd3,      16'sd1,      16'sd0,      1'b0, '0},  // numerator low bit cleared
    '{-16'sd3,     -16'sd1,     16'sd0,      1'b0, '0},
    '{16'sd4096,   16'sd2048,   16'sd4096,   1'b0, '0},  // nominal operating point
    '{16'sd4096,   -16'sd2048,  -16'sd4096,  1'b0, '0},
    '{16'sd21845,  -16'sd21846, 16'sd21845,  1'b0, '0},  // alternating bit patterns
    '{-16'sd21846, 16'sd21845,  -16'sd21846, 1'b0, '0},
    '{16'sd8192,   16'sd8192,   16'sd8191,   1'b0, '0},  // speed*4 near wrap
    '{16'sd100,    16'sd200,    16'sd8192,   1'b0, '0},  // speed*4 wraps
    '{16'sd1,      16'sd0,      -16'sd8193,  1'b0, '0}
  };

  // gain setting used by each phase after the reset-gain phase
  localparam gain_mode_e PhasePlan [5] = '{GainsMax, GainsZero, GainsMixed,
                                           GainsRandom, GainsNominal};

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [fdvs_pkg::IdxW-1:0]     cfg_idx_i     = '0;
  logic [fdvs_pkg::GainW-1:0]    cfg_wdata_i   = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  // [15:0] d_current_ref, [31:16] q_current_ref, [47:32] rotor_speed
  logic [fdvs_pkg::InW-1:0]      s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // [15:0] d_voltage_ref, [31:16] q_voltage_ref, [46:32] flux_angle,
  // [62:47] stator_frequency, [78:63] slip_frequency, [79] zero
  logic [fdvs_pkg::OutW-1:0]     m_axis_tdata;

  // predictor copy of the gain registers and the flux angle accumulator
  logic [fdvs_pkg::GainW-1:0]  rs_gain    = fdvs_pkg::RstRs;
  logic [fdvs_pkg::GainW-1:0]  sigma_gain = fdvs_pkg::RstSigma;
  logic [fdvs_pkg::GainW-1:0]  ls_gain    = fdvs_pkg::RstLs;
  logic [fdvs_pkg::GainW-1:0]  slip_gain  = fdvs_pkg::RstSlip;
  logic [fdvs_pkg::GainW-1:0]  angle_gain = fdvs_pkg::RstAngle;
  logic [fdvs_pkg::AngleW-1:0] flux_acc   = '0;

  result_t     volt_q [$];   // predicted outputs, oldest first
  int unsigned err_cnt   = 0;
  bit          src_idle  = 1'b1;
  bit          sink_idle = 1'b1;

  foc_decoupling_voltage_step u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One sample through the decoupler; advances the flux angle. Products are kept
  // exact in 64 bits, shifts floor, the divide truncates toward zero.
  function automatic result_t step_decoupler(
      input logic signed [fdvs_pkg::DataW-1:0] id,
      input logic signed [fdvs_pkg::DataW-1:0] iq,
      input logic signed [fdvs_pkg::DataW-1:0] speed);
    longint isd, isq, spd, num, slip, w, dth, vsd, vsq;
    logic signed [fdvs_pkg::DataW-1:0] w16;
    result_t r;
    isd = id;
    isq = iq;
    spd = speed;
    num = ((isq * longint'(slip_gain)) >>> 1) <<< 1;
    if (isd == 0) begin
      slip = (num < 0) ? -32768 : 32767;
    end else begin
      slip = num / isd;
      if (slip > 32767) slip = 32767;
      else if (slip < -32768) slip = -32768;
    end
    w16 = fdvs_pkg::DataW'(spd * 4 + slip);
    w   = w16;
    dth = (longint'(angle_gain) * w) >>> FreqFrac;
    flux_acc = flux_acc + dth[fdvs_pkg::AngleW-1:0];
    vsd = ((longint'(rs_gain) * isd) >>> CurFrac)
        - ((((w * isq) >>> FreqFrac) * longint'(sigma_gain)) >>> CurFrac);
    vsq = ((longint'(rs_gain) * isq) >>> CurFrac)
        + ((((w * isd) >>> FreqFrac) * longint'(ls_gain)) >>> CurFrac);
    r             = '0;
    r.d_volt      = vsd[fdvs_pkg::DataW-1:0];
    r.q_volt      = vsq[fdvs_pkg::DataW-1:0];
    r.angle       = flux_acc;
    r.stator_freq = w16;
    r.slip_freq   = slip[fdvs_pkg::DataW-1:0];
    return r;
  endfunction

  function automatic void apply_gain(input logic [fdvs_pkg::IdxW-1:0] idx,
                                     input logic [fdvs_pkg::GainW-1:0] val);
    case (idx)
      fdvs_pkg::RegRs:    rs_gain    = val;
      fdvs_pkg::RegSigma: sigma_gain = val;
      fdvs_pkg::RegLs:    ls_gain    = val;
      fdvs_pkg::RegSlip:  slip_gain  = val;
      fdvs_pkg::RegAngle: angle_gain = val;
      default: ;  // unmapped index, write dropped
    endcase
  endfunction

  function automatic logic [fdvs_pkg::GainW-1:0] pick_gain(input gain_mode_e mode);
    case (mode)
      GainsMax:     return '1;
      GainsZero:    return '0;
      GainsNominal: return fdvs_pkg::GainW'($urandom_range(0, 4095));
      GainsMixed:
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return '1;
          default: return fdvs_pkg::GainW'($urandom);
        endcase
      default:      return fdvs_pkg::GainW'($urandom);
    endcase
  endfunction

  // field value skewed toward zero, full scale, small magnitudes and the Q12 range
  function automatic logic signed [fdvs_pkg::DataW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? fdvs_pkg::SatPos : fdvs_pkg::SatNeg;
      2, 3:    return fdvs_pkg::DataW'($urandom_range(0, 64)) - 16'd32;
      4, 5:    return fdvs_pkg::DataW'($urandom_range(0, 16383)) - 16'd8192;
      default: return fdvs_pkg::DataW'($urandom);
    endcase
  endfunction

  function automatic row_t rand_row();
    row_t r;
    r       = '0;
    r.id    = rand_value();
    r.iq    = rand_value();
    r.speed = rand_value();
    return r;
  endfunction

  // Present one sample, wait for the input transfer, then queue its prediction.
  // The typed expectation wins on directed rows; the predictor still steps so the
  // angle stays in sync.
  task automatic send_sample(input row_t row);
    result_t pred;
    if (src_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row.speed, row.iq, row.id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = step_decoupler(row.id, row.iq, row.speed);
    volt_q.push_back(row.chk ? row.want : pred);
  endtask

  // Drop valid and wait for every queued result; checked on the falling edge so
  // the monitor's pop at the rising edge has already happened.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (volt_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Sweep every index value; the unmapped ones must be ignored by the block.
  task automatic load_gains(input gain_mode_e mode);
    logic [fdvs_pkg::GainW-1:0] val;
    for (int i = 0; i < 2**fdvs_pkg::IdxW; i++) begin
      val = pick_gain(mode);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= fdvs_pkg::IdxW'(i);
      cfg_wdata_i <= val;
      @(posedge clk_i);
      apply_gain(fdvs_pkg::IdxW'(i), val);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_voltages(input result_t got, input result_t exp);
    if (got.d_volt !== exp.d_volt) begin
      $error("d_voltage_ref: expected %0d, got %0d", exp.d_volt, got.d_volt);
      err_cnt++;
    end
    if (got.q_volt !== exp.q_volt) begin
      $error("q_voltage_ref: expected %0d, got %0d", exp.q_volt, got.q_volt);
      err_cnt++;
    end
    if (got.angle !== exp.angle) begin
      $error("flux_angle: expected %0d, got %0d", exp.angle, got.angle);
      err_cnt++;
    end
    if (got.stator_freq !== exp.stator_freq) begin
      $error("stator_frequency: expected %0d, got %0d", exp.stator_freq, got.stator_freq);
      err_cnt++;
    end
    if (got.slip_freq !== exp.slip_freq) begin
      $error("slip_frequency: expected %0d, got %0d", exp.slip_freq, got.slip_freq);
      err_cnt++;
    end
    if (got.pad !== exp.pad) begin
      $error("pad bit: expected %0d, got %0d", exp.pad, got.pad);
      err_cnt++;
    end
  endtask

  // output monitor: every output transfer is matched against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (volt_q.size() == 0) begin
        $error("output transfer with no prediction pending: %h", m_axis_tdata);
        err_cnt++;
      end else begin
        check_voltages(m_axis_tdata, volt_q.pop_front());
      end
    end
  end

  // sink back-pressure: random stall bursts while enabled
  initial begin : sink_pacing
    forever begin
      @(posedge clk_i);
      if (sink_idle && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners under reset gains
    foreach (DirRows[i]) send_sample(DirRows[i]);
    repeat (100) send_sample(rand_row());

    // one phase per gain setting; the last one runs with no idling on either side
    foreach (PhasePlan[p]) begin
      drain_results();
      load_gains(PhasePlan[p]);
      if (p == $size(PhasePlan) - 1) begin
        src_idle  <= 1'b0;
        sink_idle <= 1'b0;
      end
      repeat (130) send_sample(rand_row());
    end

    drain_results();
    // quiet time to catch stray output transfers
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/fdvs_pkg.sv
sv/foc_decoupling_voltage_step.sv
tb/foc_decoupling_voltage_step_tb.sv
